// ----- design/ntsp_pkg.sv -----
// Shared types and constants for the nested timer stack profiler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ntsp_pkg;

  // Default sizes
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_NUM_TIMERS  = 7;
  localparam int DEF_TIME_WIDTH  = 48;

  // Fixed field widths
  localparam int OP_W  = 3;
  localparam int ARG_W = 16;
  localparam int ERR_W = 6;

  // Sticky error bits
  localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 6'h01;
  localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 6'h02;
  localparam logic [ERR_W-1:0] ERR_BAD_RESET = 6'h04;
  localparam logic [ERR_W-1:0] ERR_NOT_STOP  = 6'h08;
  localparam logic [ERR_W-1:0] ERR_BAD_OP    = 6'h10;
  localparam logic [ERR_W-1:0] ERR_BAD_ID    = 6'h20;

  typedef enum logic [OP_W-1:0] {
    OP_RESET    = 3'd0,
    OP_PUSH     = 3'd1,
    OP_POP      = 3'd2,
    OP_HALT_ALL = 3'd3,
    OP_REPORT   = 3'd4
  } opcode_e;

  // Write strobes from the sequencer into the timer register file
  typedef struct packed {
    logic clr_acc;
    logic wr_start;
    logic wr_acc;
  } timer_cmd_t;

endpackage

// ----- design/ntsp_id_stack.sv -----
// Timer id stack storage: one write port, one registered read port.
// Depends on ntsp_pkg.
`timescale 1ns / 1ps

module ntsp_id_stack
  import ntsp_pkg::*;
#(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int WIDTH = 3
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, read every cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ntsp_alu.sv -----
// Shared add/subtract unit with a result register, used for elapsed-time
// spans and for accumulating totals. Depends on ntsp_pkg.
`timescale 1ns / 1ps

module ntsp_alu
  import ntsp_pkg::*;
#(
  parameter int WIDTH = DEF_TIME_WIDTH
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  input  logic             ld_i,
  output logic [WIDTH-1:0] sum_o,
  output logic [WIDTH-1:0] res_o
);

  logic [WIDTH-1:0] b_op;
  logic [WIDTH-1:0] res_q;

  // a + b or a - b, modulo 2^WIDTH
  assign b_op  = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_op + WIDTH'(sub_i);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= sum_o;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/ntsp_timer_file.sv -----
// Per-timer start stamps and accumulated totals with one shared read index.
// Depends on ntsp_pkg (timer_cmd_t).
`timescale 1ns / 1ps

module ntsp_timer_file
  import ntsp_pkg::*;
#(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int IDX_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  timer_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [TIME_WIDTH-1:0] acc_wdata_i,
  output logic [TIME_WIDTH-1:0] start_rd_o,
  output logic [TIME_WIDTH-1:0] acc_rd_o
);

  logic [TIME_WIDTH-1:0] start_q [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] acc_q   [NUM_TIMERS];
  logic                  wr_ok;
  logic                  rd_ok;

  assign wr_ok = (wr_idx_i < NUM_TIMERS);
  assign rd_ok = (rd_idx_i < NUM_TIMERS);

  // Stamp and total registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        start_q[i] <= '0;
        acc_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.clr_acc) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          acc_q[i] <= '0;
        end
      end
      if (cmd_i.wr_start && wr_ok) begin
        start_q[wr_idx_i] <= now_i;
      end
      if (cmd_i.wr_acc && wr_ok) begin
        acc_q[wr_idx_i] <= acc_wdata_i;
      end
    end
  end

  // Shared read index
  assign start_rd_o = rd_ok ? start_q[rd_idx_i] : '0;
  assign acc_rd_o   = rd_ok ? acc_q[rd_idx_i]   : '0;

endmodule

// ----- design/nested_timer_stack_profiler.sv -----
// Nested timer stack profiler top: sequencer, stack, shared adder, timer file.
// A status result passes through decode and, when a push or pop halts and restarts a
// timer (two passes through the adder), the halt-read, halt-add and then push-write
// or launch steps before it is registered. A new input is taken only once the last
// result is registered; a report gives NUM_TIMERS results, one per cycle unless stalled.
// Reset (rst_ni low, async) empties the stack, clears totals and errors, uninitialized.
`timescale 1ns / 1ps

module nested_timer_stack_profiler
  import ntsp_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_TIMERS  = DEF_NUM_TIMERS,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int CntW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [ARG_W-1:0] argument_i,
  input  logic [TIME_WIDTH-1:0]   timestamp_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IdxW-1:0]         timer_index_o,
  output logic [TIME_WIDTH-1:0]   total_ticks_o,
  output logic [ERR_W-1:0]        error_mask_o,
  output logic [CntW-1:0]         stack_depth_o,
  output logic                    initialized_o,
  output logic                    last_o
);

  localparam int AddrW  = $clog2(STACK_DEPTH);
  localparam int NSlots = 1 << IdxW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HALT_RD,
    ST_HALT_ADD,
    ST_PUSH_WR,
    ST_LAUNCH,
    ST_EMIT,
    ST_REPORT
  } state_e;

  state_e                 state_q;
  state_e                 post_state;
  logic [OP_W-1:0]        op_q;
  logic signed [ARG_W-1:0] arg_q;
  logic [TIME_WIDTH-1:0]  now_q;
  logic [CntW-1:0]        count_q;
  logic                   ready_q;
  logic [NUM_TIMERS-1:0]  running_q;
  logic [ERR_W-1:0]       err_q;
  logic [IdxW-1:0]        hid_q;
  logic [IdxW-1:0]        rep_idx_q;

  logic                   out_valid_q;
  logic [IdxW-1:0]        out_idx_q;
  logic [TIME_WIDTH-1:0]  out_total_q;
  logic [ERR_W-1:0]       out_err_q;
  logic [CntW-1:0]        out_depth_q;
  logic                   out_init_q;
  logic                   out_last_q;

  // Decode helpers
  logic [ARG_W-1:0]       arg_u;
  logic                   arg_bad_id;
  logic                   arg_nonpos;
  logic [IdxW-1:0]        arg_id;
  logic                   stack_full;
  logic                   stack_empty;
  logic [CntW-1:0]        cnt_m1;
  logic                   out_free;
  logic                   out_load;

  // Stack, timer file and adder hookup
  logic [IdxW-1:0]        rd_id;
  logic                   rd_ok;
  logic [NSlots-1:0]      run_pad;
  logic                   rd_running;
  logic                   stk_we;
  timer_cmd_t             tcmd;
  logic [IdxW-1:0]        t_wr_idx;
  logic [IdxW-1:0]        t_rd_idx;
  logic [TIME_WIDTH-1:0]  start_rd;
  logic [TIME_WIDTH-1:0]  acc_rd;
  logic [TIME_WIDTH-1:0]  alu_a;
  logic [TIME_WIDTH-1:0]  alu_b;
  logic                   alu_sub;
  logic                   alu_ld;
  logic [TIME_WIDTH-1:0]  alu_sum;
  logic [TIME_WIDTH-1:0]  alu_res;
  logic [NSlots-1:0]      oh_hid;
  logic [NSlots-1:0]      oh_arg;
  logic [NSlots-1:0]      oh_rd;

  assign arg_u       = arg_q;
  assign arg_bad_id  = arg_q[ARG_W-1] || (arg_u >= ARG_W'(NUM_TIMERS));
  assign arg_nonpos  = arg_q[ARG_W-1] || (arg_u == '0);
  assign arg_id      = arg_u[IdxW-1:0];
  assign stack_full  = (count_q == CntW'(STACK_DEPTH));
  assign stack_empty = (count_q == '0);
  assign cnt_m1      = count_q - CntW'(1);
  assign out_free    = !out_valid_q || !out_stall_i;
  // Output register takes a new result this cycle
  assign out_load    = ((state_q == ST_EMIT) || (state_q == ST_REPORT)) && out_free;

  assign rd_ok      = (rd_id < NUM_TIMERS);
  assign run_pad    = NSlots'(running_q);
  assign rd_running = rd_ok && run_pad[rd_id];
  assign oh_hid     = NSlots'(1) << hid_q;
  assign oh_arg     = NSlots'(1) << arg_id;
  assign oh_rd      = NSlots'(1) << rd_id;

  // Stack of timer ids; read port always follows the current top
  ntsp_id_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (IdxW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (arg_id),
    .raddr_i (cnt_m1[AddrW-1:0]),
    .rdata_o (rd_id)
  );

  ntsp_timer_file #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IdxW)
  ) u_timers (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (tcmd),
    .wr_idx_i    (t_wr_idx),
    .rd_idx_i    (t_rd_idx),
    .now_i       (now_q),
    .acc_wdata_i (alu_sum),
    .start_rd_o  (start_rd),
    .acc_rd_o    (acc_rd)
  );

  ntsp_alu #(
    .WIDTH (TIME_WIDTH)
  ) u_alu (
    .clk_i (clk_i),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .ld_i  (alu_ld),
    .sum_o (alu_sum),
    .res_o (alu_res)
  );

  // Where to go once the top timer has been halted
  always_comb begin
    unique case (opcode_e'(op_q))
      OP_PUSH: post_state = ST_PUSH_WR;
      OP_POP:  post_state = stack_empty ? ST_EMIT : ST_LAUNCH;
      default: post_state = ST_EMIT;
    endcase
  end

  // Datapath strobes per sequencer step
  always_comb begin
    stk_we   = 1'b0;
    tcmd     = '0;
    t_wr_idx = rd_id;
    t_rd_idx = rd_id;
    alu_a    = now_q;
    alu_b    = start_rd;
    alu_sub  = 1'b1;
    alu_ld   = 1'b0;
    unique case (state_q)
      ST_DECODE: begin
        tcmd.clr_acc = (opcode_e'(op_q) == OP_RESET);
      end
      ST_HALT_RD: begin
        // span = now - start of the halted timer
        alu_ld = rd_running;
      end
      ST_HALT_ADD: begin
        // total += span
        t_rd_idx    = hid_q;
        t_wr_idx    = hid_q;
        alu_a       = acc_rd;
        alu_b       = alu_res;
        alu_sub     = 1'b0;
        tcmd.wr_acc = 1'b1;
      end
      ST_PUSH_WR: begin
        stk_we        = 1'b1;
        t_wr_idx      = arg_id;
        tcmd.wr_start = 1'b1;
      end
      ST_LAUNCH: begin
        tcmd.wr_start = 1'b1;
      end
      ST_REPORT: begin
        t_rd_idx = rep_idx_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, architectural state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      arg_q       <= '0;
      now_q       <= '0;
      count_q     <= '0;
      ready_q     <= 1'b0;
      running_q   <= '0;
      err_q       <= '0;
      hid_q       <= '0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_total_q <= '0;
      out_err_q   <= '0;
      out_depth_q <= '0;
      out_init_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            arg_q   <= argument_i;
            now_q   <= timestamp_i;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (!ready_q && (opcode_e'(op_q) != OP_RESET)) begin
            state_q <= ST_EMIT;
          end else begin
            unique case (opcode_e'(op_q))
              OP_RESET: begin
                count_q   <= '0;
                running_q <= '0;
                ready_q   <= 1'b1;
                if (arg_nonpos) begin
                  err_q <= err_q | ERR_BAD_RESET;
                end
                state_q <= ST_EMIT;
              end
              OP_PUSH: begin
                if (arg_bad_id) begin
                  err_q   <= err_q | ERR_BAD_ID;
                  state_q <= ST_EMIT;
                end else if (stack_full) begin
                  err_q   <= err_q | ERR_PUSH_FULL;
                  state_q <= ST_EMIT;
                end else if (stack_empty) begin
                  state_q <= ST_PUSH_WR;
                end else begin
                  state_q <= ST_HALT_RD;
                end
              end
              OP_POP: begin
                if (stack_empty) begin
                  err_q   <= err_q | ERR_POP_EMPTY;
                  state_q <= ST_EMIT;
                end else begin
                  count_q <= cnt_m1;
                  state_q <= ST_HALT_RD;
                end
              end
              OP_HALT_ALL: begin
                count_q <= '0;
                state_q <= stack_empty ? ST_EMIT : ST_HALT_RD;
              end
              OP_REPORT: begin
                if (!stack_empty) begin
                  err_q <= err_q | ERR_NOT_STOP;
                end
                count_q   <= '0;
                ready_q   <= 1'b0;
                rep_idx_q <= '0;
                state_q   <= ST_REPORT;
              end
              default: begin
                err_q   <= err_q | ERR_BAD_OP;
                state_q <= ST_EMIT;
              end
            endcase
          end
        end
        ST_HALT_RD: begin
          // stack read issued in the decode step is valid here
          hid_q   <= rd_id;
          state_q <= rd_running ? ST_HALT_ADD : post_state;
        end
        ST_HALT_ADD: begin
          running_q <= running_q & ~oh_hid[NUM_TIMERS-1:0];
          state_q   <= post_state;
        end
        ST_PUSH_WR: begin
          count_q   <= count_q + CntW'(1);
          running_q <= running_q | oh_arg[NUM_TIMERS-1:0];
          state_q   <= ST_EMIT;
        end
        ST_LAUNCH: begin
          // restart the timer now on top of the stack
          if (rd_ok) begin
            running_q <= running_q | oh_rd[NUM_TIMERS-1:0];
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= '0;
            out_total_q <= '0;
            out_err_q   <= err_q;
            out_depth_q <= count_q;
            out_init_q  <= ready_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= rep_idx_q;
            out_total_q <= acc_rd;
            out_err_q   <= err_q;
            out_depth_q <= count_q;
            out_init_q  <= ready_q;
            out_last_q  <= (rep_idx_q == IdxW'(NUM_TIMERS - 1));
            if (rep_idx_q == IdxW'(NUM_TIMERS - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              rep_idx_q <= rep_idx_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign timer_index_o = out_idx_q;
  assign total_ticks_o = out_total_q;
  assign error_mask_o  = out_err_q;
  assign stack_depth_o = out_depth_q;
  assign initialized_o = out_init_q;
  assign last_o        = out_last_q;

  // Stack fill never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Error bits only ever get set
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((err_q & $past(err_q)) == $past(err_q)))
    else $error("sticky error bit cleared");

  // Only the top of the stack runs
  a_one_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(running_q))
    else $error("more than one timer running");

  // Results that are not last come only from a report
  a_report_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (!initialized_o && (stack_depth_o == '0)))
    else $error("non-final result outside a report");

endmodule
